// ===== hw/rtl/tfn_pkg.sv =====
// Shared widths and types for the triangle face normal pipeline.
`default_nettype none
package tfn_pkg;
    localparam int CoordW = 24;
    localparam int EdgeW  = 25;
    localparam int ProdW  = 50;
    localparam int MagW   = 49;
    localparam int LoW    = 25;
    localparam int HiW    = MagW - LoW;
    localparam int SqW    = 2 * MagW;
    localparam int SumW   = SqW + 2;
    localparam int LenW   = SumW / 2;
    localparam int FracW  = 14;
    localparam int NumW   = MagW + FracW + 2;
    localparam int QuoW   = FracW + 1;
    localparam int NormW  = 16;
    localparam int LimW   = 16;
    localparam int LimReset = 7;

    typedef struct packed {
        logic [2:0]           neg;
        logic [2:0][MagW-1:0] mag;
    } cross_t;

    typedef struct packed {
        logic                 degen;
        logic [2:0]           neg;
    } div_side_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tfn_cross.sv =====
// Edge vectors, products and cross product with magnitude and sign split.
`default_nettype none
module tfn_cross (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [tfn_pkg::CoordW-1:0] first_x,
    input  logic [tfn_pkg::CoordW-1:0] first_y,
    input  logic [tfn_pkg::CoordW-1:0] first_z,
    input  logic [tfn_pkg::CoordW-1:0] second_x,
    input  logic [tfn_pkg::CoordW-1:0] second_y,
    input  logic [tfn_pkg::CoordW-1:0] second_z,
    input  logic [tfn_pkg::CoordW-1:0] third_x,
    input  logic [tfn_pkg::CoordW-1:0] third_y,
    input  logic [tfn_pkg::CoordW-1:0] third_z,
    output logic                       out_valid,
    output tfn_pkg::cross_t            cr_out
);
    import tfn_pkg::*;

    logic signed [EdgeW-1:0] a_reg [3];
    logic signed [EdgeW-1:0] b_reg [3];
    logic signed [ProdW-1:0] p_reg [6];
    cross_t                  c_reg;
    logic [2:0]              v_reg;
    logic signed [ProdW:0]   c_next [3];

    function automatic logic signed [EdgeW-1:0] edge_of(logic [CoordW-1:0] p,
                                                       logic [CoordW-1:0] q);
        return $signed({p[CoordW-1], p}) - $signed({q[CoordW-1], q});
    endfunction

    always_comb
    begin
        c_next[0] = {p_reg[0][ProdW-1], p_reg[0]} - {p_reg[1][ProdW-1], p_reg[1]};
        c_next[1] = {p_reg[2][ProdW-1], p_reg[2]} - {p_reg[3][ProdW-1], p_reg[3]};
        c_next[2] = {p_reg[4][ProdW-1], p_reg[4]} - {p_reg[5][ProdW-1], p_reg[5]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg[0] <= edge_of(second_x, first_x);
            a_reg[1] <= edge_of(second_y, first_y);
            a_reg[2] <= edge_of(second_z, first_z);
            b_reg[0] <= edge_of(third_x, first_x);
            b_reg[1] <= edge_of(third_y, first_y);
            b_reg[2] <= edge_of(third_z, first_z);
            p_reg[0] <= a_reg[1] * b_reg[2];
            p_reg[1] <= a_reg[2] * b_reg[1];
            p_reg[2] <= a_reg[2] * b_reg[0];
            p_reg[3] <= a_reg[0] * b_reg[2];
            p_reg[4] <= a_reg[0] * b_reg[1];
            p_reg[5] <= a_reg[1] * b_reg[0];
            for (int j = 0; j < 3; j++)
            begin
                c_reg.neg[j] <= c_next[j][ProdW];
                c_reg.mag[j] <= c_next[j][ProdW] ? MagW'(-c_next[j]) : MagW'(c_next[j]);
            end
        end
    end

    assign out_valid = v_reg[2];
    assign cr_out    = c_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/tfn_square.sv =====
// Sum of squared cross components, each square built from partial products of its 24-bit high and 25-bit low halves.
`default_nettype none
module tfn_square (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  tfn_pkg::cross_t          cr_in,
    output logic                     out_valid,
    output logic [tfn_pkg::SumW-1:0] sum,
    output tfn_pkg::cross_t          side
);
    import tfn_pkg::*;

    logic [2*HiW-1:0]     hh_reg [3];
    logic [HiW+LoW-1:0]   hl_reg [3];
    logic [2*LoW-1:0]     ll_reg [3];
    logic [SqW-1:0]       sq_reg [3];
    logic [SumW-1:0]      sum_reg;
    cross_t               s_reg [3];
    logic [2:0]           v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                hh_reg[j] <= cr_in.mag[j][MagW-1:LoW] * cr_in.mag[j][MagW-1:LoW];
                hl_reg[j] <= cr_in.mag[j][MagW-1:LoW] * cr_in.mag[j][LoW-1:0];
                ll_reg[j] <= cr_in.mag[j][LoW-1:0] * cr_in.mag[j][LoW-1:0];
                sq_reg[j] <= (SqW'(hh_reg[j]) << (2 * LoW)) + (SqW'(hl_reg[j]) << (LoW + 1))
                             + SqW'(ll_reg[j]);
            end
            sum_reg  <= SumW'(sq_reg[0]) + SumW'(sq_reg[1]) + SumW'(sq_reg[2]);
            s_reg[0] <= cr_in;
            s_reg[1] <= s_reg[0];
            s_reg[2] <= s_reg[1];
        end
    end

    assign out_valid = v_reg[2];
    assign sum       = sum_reg;
    assign side      = s_reg[2];
endmodule
`default_nettype wire

// ===== hw/rtl/tfn_sqrt.sv =====
// Integer square root, one root bit resolved per pipeline stage.
`default_nettype none
module tfn_sqrt (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [tfn_pkg::SumW-1:0] sum,
    input  tfn_pkg::cross_t          side_in,
    output logic                     out_valid,
    output logic [tfn_pkg::LenW-1:0] root,
    output tfn_pkg::cross_t          side_out
);
    import tfn_pkg::*;

    logic [SumW-1:0] rem_reg  [LenW+1];
    logic [LenW-1:0] root_reg [LenW+1];
    cross_t          side_reg [LenW+1];
    logic [LenW:0]   v_reg;

    assign rem_reg[0]  = sum;
    assign root_reg[0] = '0;
    assign side_reg[0] = side_in;
    assign v_reg[0]    = in_valid;

    for (genvar i = 0; i < LenW; i++)
    begin : g_stage
        localparam int B = LenW - 1 - i;
        logic [SumW+1:0] trial;
        logic            take;

        // Trial value is (2*root + 2^b) * 2^b, the growth of the square.
        assign trial = ((SumW+2)'(root_reg[i]) << (B + 1)) | ((SumW+2)'(1) << (2 * B));
        assign take  = (SumW+2)'(rem_reg[i]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (adv)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i+1]  <= take ? SumW'((SumW+2)'(rem_reg[i]) - trial) : rem_reg[i];
                root_reg[i+1] <= take ? (root_reg[i] | (LenW'(1) << B)) : root_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = v_reg[LenW];
    assign root      = root_reg[LenW];
    assign side_out  = side_reg[LenW];
endmodule
`default_nettype wire

// ===== hw/rtl/tfn_div.sv =====
// Degenerate test and three restoring dividers, one quotient bit per stage.
`default_nettype none
module tfn_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [tfn_pkg::LenW-1:0]  len,
    input  tfn_pkg::cross_t           side,
    input  logic [tfn_pkg::LimW-1:0]  limit,
    output logic                      out_valid,
    output logic [tfn_pkg::NormW-1:0] norm [3],
    output logic                      degen
);
    import tfn_pkg::*;

    logic [NumW-1:0] rem_reg [QuoW+1][3];
    logic [QuoW-1:0] quo_reg [QuoW+1][3];
    logic [LenW-1:0] len_reg [QuoW+1];
    div_side_t       sd_reg  [QuoW+1];
    logic [QuoW+1:0] v_reg;
    logic [NormW-1:0] norm_reg [3];
    logic             degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[QuoW:0], in_valid};
    end

    // Numerator carries half the length so the quotient rounds half up.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rem_reg[0][j] <= (NumW'(side.mag[j]) << FracW) + NumW'(len >> 1);
                quo_reg[0][j] <= '0;
            end
            len_reg[0]      <= len;
            sd_reg[0].neg   <= side.neg;
            sd_reg[0].degen <= (len >> 16) <= LenW'(limit);
        end
    end

    for (genvar k = 0; k < QuoW; k++)
    begin : g_stage
        localparam int B = QuoW - 1 - k;
        logic [NumW-1:0] dv;

        assign dv = NumW'(len_reg[k]) << B;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (rem_reg[k][j] >= dv)
                    begin
                        rem_reg[k+1][j] <= rem_reg[k][j] - dv;
                        quo_reg[k+1][j] <= quo_reg[k][j] | (QuoW'(1) << B);
                    end
                    else
                    begin
                        rem_reg[k+1][j] <= rem_reg[k][j];
                        quo_reg[k+1][j] <= quo_reg[k][j];
                    end
                end
                len_reg[k+1] <= len_reg[k];
                sd_reg[k+1]  <= sd_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            degen_reg <= sd_reg[QuoW].degen;
            for (int j = 0; j < 3; j++)
            begin
                if (sd_reg[QuoW].degen)
                    norm_reg[j] <= '0;
                else if (sd_reg[QuoW].neg[j])
                    norm_reg[j] <= -NormW'(quo_reg[QuoW][j]);
                else
                    norm_reg[j] <= NormW'(quo_reg[QuoW][j]);
            end
        end
    end

    assign out_valid = v_reg[QuoW+1];
    assign norm      = norm_reg;
    assign degen     = degen_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/triangle_face_normal_top.sv =====
// Top level of the triangle face normal pipeline.
//
//  port group    direction  handshake            payload
//  in            to block   in_valid/in_stall    first_*, second_*, third_* (Q8.16)
//  out           from block out_valid/out_stall  normal_x/y/z (Q1.14), degenerate
//  cfg           to block   cfg_wr_en            cfg_wr_data = degenerate limit
//
// One word enters per cycle while in_stall is low; the stages are 3 cross, 3 square,
// 50 square root (one root bit per stage), 1 setup, 15 divide, 1 output.
// A stalled result freezes the whole pipeline; in_stall is raised only while a valid result is stalled.
// Reset clears all valid bits and sets the limit to 7.
`default_nettype none
module triangle_face_normal_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tfn_pkg::CoordW-1:0]        first_x,
    input  logic [tfn_pkg::CoordW-1:0]        first_y,
    input  logic [tfn_pkg::CoordW-1:0]        first_z,
    input  logic [tfn_pkg::CoordW-1:0]        second_x,
    input  logic [tfn_pkg::CoordW-1:0]        second_y,
    input  logic [tfn_pkg::CoordW-1:0]        second_z,
    input  logic [tfn_pkg::CoordW-1:0]        third_x,
    input  logic [tfn_pkg::CoordW-1:0]        third_y,
    input  logic [tfn_pkg::CoordW-1:0]        third_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [tfn_pkg::NormW-1:0]  normal_x,
    output logic signed [tfn_pkg::NormW-1:0]  normal_y,
    output logic signed [tfn_pkg::NormW-1:0]  normal_z,
    output logic                              degenerate,
    input  logic                              cfg_wr_en,
    input  logic [tfn_pkg::LimW-1:0]          cfg_wr_data
);
    import tfn_pkg::*;

    logic            adv;
    logic [LimW-1:0] limit_reg;
    logic            cr_valid, sq_valid, rt_valid;
    cross_t          cr_data, sq_side, rt_side;
    logic [SumW-1:0] sq_sum;
    logic [LenW-1:0] rt_len;
    logic [NormW-1:0] norm [3];

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LimW'(LimReset);
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    tfn_cross u_cross (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid),
        .first_x(first_x), .first_y(first_y), .first_z(first_z),
        .second_x(second_x), .second_y(second_y), .second_z(second_z),
        .third_x(third_x), .third_y(third_y), .third_z(third_z),
        .out_valid(cr_valid), .cr_out(cr_data)
    );

    tfn_square u_square (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(cr_valid), .cr_in(cr_data),
        .out_valid(sq_valid), .sum(sq_sum), .side(sq_side)
    );

    tfn_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(sq_valid), .sum(sq_sum),
        .side_in(sq_side), .out_valid(rt_valid), .root(rt_len), .side_out(rt_side)
    );

    tfn_div u_div (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(rt_valid), .len(rt_len),
        .side(rt_side), .limit(limit_reg), .out_valid(out_valid), .norm(norm),
        .degen(degenerate)
    );

    assign normal_x = norm[0];
    assign normal_y = norm[1];
    assign normal_z = norm[2];

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
        else $error("degenerate word carries a nonzero normal");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> normal_x <= 16384 && normal_x >= -16384 &&
                      normal_y <= 16384 && normal_y >= -16384 &&
                      normal_z <= 16384 && normal_z >= -16384)
        else $error("normal component outside unit range");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the output is free");
`endif
endmodule
`default_nettype wire
